FILE: design/fsp_pkg.sv
// Shared types and constants for the float switch pump timer.
// Holds the request, result and register structs, mode codes and register indexes.
// Depends on nothing; every other file uses it.
package fsp_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [TimeW-1:0] OnTimeRst = TimeW'(1000 * 60 * 3);
  localparam logic [TimeW-1:0] RestFullRst = TimeW'(1000 * 60 * 120);
  localparam logic [TimeW-1:0] RestEmptyRst = TimeW'(1000 * 60 * 20);
  localparam logic [TimeW-1:0] LockoutRst = TimeW'(1000 * 20);

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] CfgOnTime = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgRestFull = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgRestEmpty = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgLockout = CfgIdxW'(3);

  typedef enum logic [1:0] {
    ModeAuto = 2'd0,
    ModeOn   = 2'd1,
    ModeOff  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             float_level;
    logic             button_press;
    logic             remote_mode_valid;
    logic [1:0]       remote_mode;
  } in_t;

  typedef struct packed {
    logic       relay_drive;
    logic       led_one;
    logic       led_two;
    logic [1:0] current_mode;
    logic       full_notice;
  } out_t;

  typedef struct packed {
    logic [TimeW-1:0] on_time_ms;
    logic [TimeW-1:0] rest_after_full_ms;
    logic [TimeW-1:0] rest_after_empty_ms;
    logic [TimeW-1:0] relay_lockout_ms;
  } cfg_t;

endpackage

FILE: design/fsp_if.sv
// Handshake channels of the float switch pump timer: request, result and register write.
// Depends on fsp_pkg for the payload types.
interface fsp_in_if;
  logic         valid;
  logic         ready;
  fsp_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fsp_out_if;
  logic          valid;
  logic          ready;
  fsp_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fsp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fsp_pkg::CfgIdxW-1:0]  index;
  logic [fsp_pkg::TimeW-1:0]    wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: design/fsp_cfg_regs.sv
// Timing register bank of the pump timer, written through the configuration channel.
// Depends on fsp_pkg and fsp_cfg_if.
module fsp_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  fsp_cfg_if.sink          cfg_i,
  output fsp_pkg::cfg_t    cfg_o
);
  import fsp_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_time_ms <= OnTimeRst;
      cfg_q.rest_after_full_ms <= RestFullRst;
      cfg_q.rest_after_empty_ms <= RestEmptyRst;
      cfg_q.relay_lockout_ms <= LockoutRst;
    end else if (cfg_i.valid) begin
      // unknown indexes are dropped
      case (cfg_i.index)
        CfgOnTime:    cfg_q.on_time_ms <= cfg_i.wdata;
        CfgRestFull:  cfg_q.rest_after_full_ms <= cfg_i.wdata;
        CfgRestEmpty: cfg_q.rest_after_empty_ms <= cfg_i.wdata;
        CfgLockout:   cfg_q.relay_lockout_ms <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

endmodule

FILE: design/fsp_in_stage.sv
// Input register of the pump timer: captures one request and holds it until processed.
// Depends on fsp_pkg and fsp_in_if.
module fsp_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  fsp_in_if.sink        in_i,
  input  logic          advance_i,
  output logic          valid_o,
  output fsp_pkg::in_t  item_o
);
  import fsp_pkg::*;

  logic valid_q;
  in_t  item_q;

  // take a new request when empty or when the held one moves on this cycle
  assign in_i.ready = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.data;
    end
  end

endmodule

FILE: design/fsp_step.sv
// Per-request pump control: mode, LED refresh, run/rest timer, float and relay lockout.
// Holds the controller state; depends on fsp_pkg.
module fsp_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  fsp_pkg::in_t   item_i,
  input  fsp_pkg::cfg_t  cfg_i,
  output fsp_pkg::out_t  result_o
);
  import fsp_pkg::*;

  mode_e            mode_q, mode_d;
  logic             stale_q, stale_d;
  logic [1:0]       led_q, led_d;
  logic             float_q, float_d;
  logic             relay_q, relay_d;
  logic             req_q, req_d;
  logic             long_q, long_d;
  logic [TimeW-1:0] phase_q, phase_d;
  logic [TimeW-1:0] last_q, last_d;
  logic             notice;

  always_comb begin
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] rest;
    logic [TimeW-1:0] since_phase;
    logic [TimeW-1:0] since_change;
    now = item_i.now_ms;
    mode_d = mode_q;
    stale_d = stale_q;
    led_d = led_q;
    req_d = req_q;
    long_d = long_q;
    phase_d = phase_q;
    last_d = last_q;
    relay_d = relay_q;
    notice = 1'b0;

    if (item_i.button_press) begin
      mode_d = (mode_q == ModeOff) ? ModeAuto : mode_e'(mode_q + 2'd1);
      stale_d = 1'b1;
    end
    // remote code three is ignored
    if (item_i.remote_mode_valid && item_i.remote_mode <= ModeOff) begin
      mode_d = mode_e'(item_i.remote_mode);
      stale_d = 1'b1;
    end

    if (stale_d) begin
      stale_d = 1'b0;
      case (mode_d)
        ModeAuto: led_d = {relay_q, 1'b1};
        ModeOn: begin
          led_d = 2'b10;
          req_d = 1'b1;
        end
        ModeOff: begin
          led_d = 2'b00;
          req_d = 1'b0;
        end
        default: ;
      endcase
    end

    rest = long_q ? cfg_i.rest_after_full_ms : cfg_i.rest_after_empty_ms;
    since_phase = now - phase_q;
    if (!relay_q) begin
      // a zero phase start means the pump never ran: request at once
      if (phase_q == '0 || since_phase > rest) begin
        phase_d = now;
        req_d = 1'b1;
      end
    end else if (since_phase > cfg_i.on_time_ms) begin
      phase_d = now;
      req_d = 1'b0;
    end

    float_d = item_i.float_level;
    if (item_i.float_level && !float_q) begin
      long_d = 1'b1;
    end

    if (float_d && relay_q) begin
      req_d = 1'b0;
    end
    since_change = now - last_q;
    if (req_d != relay_q && since_change > cfg_i.relay_lockout_ms) begin
      stale_d = 1'b1;
      long_d = float_d;
      notice = float_d;
      relay_d = req_d;
      phase_d = now;
      last_d = now;
    end

    // timestamp went backwards: pull the phase start down to it
    if (now < phase_d) begin
      phase_d = now;
    end
  end

  assign result_o.relay_drive = relay_d;
  assign result_o.led_one = led_d[0];
  assign result_o.led_two = led_d[1];
  assign result_o.current_mode = mode_d;
  assign result_o.full_notice = notice;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeAuto;
      stale_q <= 1'b1;
      led_q <= 2'b00;
      float_q <= 1'b0;
      relay_q <= 1'b0;
      req_q <= 1'b0;
      long_q <= 1'b0;
      phase_q <= '0;
      last_q <= '0;
    end else if (advance_i) begin
      mode_q <= mode_d;
      stale_q <= stale_d;
      led_q <= led_d;
      float_q <= float_d;
      relay_q <= relay_d;
      req_q <= req_d;
      long_q <= long_d;
      phase_q <= phase_d;
      last_q <= last_d;
    end
  end

`ifndef ASSERT_OFF
  a_notice_needs_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && notice |-> relay_d != relay_q)
    else $error("full notice without relay change");

  a_change_stamps_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && relay_d != relay_q |=> last_q == $past(item_i.now_ms) && stale_q)
    else $error("relay change did not record its time or mark LEDs stale");

  a_phase_not_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |=> phase_q <= $past(item_i.now_ms))
    else $error("phase start ahead of timestamp");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(relay_q) && $stable(mode_q) && $stable(phase_q))
    else $error("state moved without a request");
`endif

endmodule

FILE: design/fsp_out_stage.sv
// Result register of the pump timer: holds one result until the sink takes it.
// Depends on fsp_pkg and fsp_out_if.
module fsp_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  fsp_pkg::out_t  result_i,
  output logic           space_o,
  fsp_out_if.source      out_o
);
  import fsp_pkg::*;

  logic valid_q;
  out_t data_q;

  assign space_o = !valid_q || out_o.ready;
  assign out_o.valid = valid_q;
  assign out_o.data = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

FILE: design/float_switch_pump_timer_core.sv
// Channel   Dir  Handshake        Payload
// in_i      in   valid/ready      now_ms, float_level, button_press, remote mode
// out_o     out  valid/ready      relay_drive, led_one, led_two, current_mode, full_notice
// cfg_i     in   valid/ready      index, wdata (four 32-bit timing registers)
//
// A request is registered in the input register, processed by the step logic and its
// result registered in the result register; a stalled result can hold it in between.
// One request per cycle is sustained while the result sink keeps taking results;
// the single step stage sets that rate.
// Reset is asynchronous and restores the default timings, automatic mode and relay off.
// A stalled result holds the step stage and then the input register.
// Top level of the float switch pump timer; depends on fsp_pkg, the channel interfaces
// and the fsp_cfg_regs, fsp_in_stage, fsp_step and fsp_out_stage modules.
module float_switch_pump_timer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsp_in_if.sink     in_i,
  fsp_out_if.source  out_o,
  fsp_cfg_if.sink    cfg_i
);
  import fsp_pkg::*;

  cfg_t cfg;
  in_t  item;
  out_t result;
  logic item_valid;
  logic out_space;
  logic advance;

  // process the held request whenever the result register can take it
  assign advance = item_valid && out_space;

  fsp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fsp_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  fsp_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  fsp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result),
    .space_o  (out_space),
    .out_o    (out_o)
  );

endmodule

FILE: tb/sv/float_switch_pump_timer_core_test.sv
// Self-checking bench for float_switch_pump_timer_core: directed, extreme and random runs.
// Predicts every status word in-bench and compares it against the result channel.
// Depends on fsp_pkg, the fsp channel interfaces and the core itself.
`timescale 1ns / 1ps

module float_switch_pump_timer_core_test;
  import fsp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHoldCycles = 60;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned MaxReports = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  fsp_in_if  in_ch ();
  fsp_out_if out_ch ();
  fsp_cfg_if cfg_ch ();

  float_switch_pump_timer_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the controller
  cfg_t             timing_shadow;
  mode_e            mode_q;
  logic             led_stale_q;
  logic [1:0]       led_pair_q;
  logic             float_seen_q;
  logic             relay_on_q;
  logic             pump_request_q;
  logic             long_rest_q;
  logic [TimeW-1:0] phase_start_q;
  logic [TimeW-1:0] last_change_q;

  out_t expected_status_q[$];

  bit               idle_en = 1'b1;
  int unsigned      hold_requests = 0;
  int unsigned      hold_served = 0;
  int unsigned      hold_left = 0;
  int unsigned      sink_gap_left = 0;
  int unsigned      cycle_count = 0;
  int unsigned      sent_count = 0;
  int unsigned      checked_count = 0;
  int unsigned      error_count = 0;
  int unsigned      reg_write_count = 0;
  int unsigned      full_stop_count = 0;
  logic [TimeW-1:0] clock_ms = '0;
  logic             tank_full = 1'b0;

  function automatic out_t predict_pump_step(input in_t req);
    out_t             res;
    logic [TimeW-1:0] rest_ms;
    logic [TimeW-1:0] since_phase;
    logic [TimeW-1:0] since_change;
    logic             notice;
    notice = 1'b0;
    if (req.button_press) begin
      case (mode_q)
        ModeAuto: mode_q = ModeOn;
        ModeOn:   mode_q = ModeOff;
        default:  mode_q = ModeAuto;
      endcase
      led_stale_q = 1'b1;
    end
    // the unused fourth code is dropped like an invalid remote request
    if (req.remote_mode_valid && req.remote_mode <= ModeOff) begin
      mode_q = mode_e'(req.remote_mode);
      led_stale_q = 1'b1;
    end
    if (led_stale_q) begin
      led_stale_q = 1'b0;
      case (mode_q)
        ModeAuto: led_pair_q = {relay_on_q, 1'b1};
        ModeOn: begin
          led_pair_q = 2'b10;
          pump_request_q = 1'b1;
        end
        default: begin
          led_pair_q = 2'b00;
          pump_request_q = 1'b0;
        end
      endcase
    end
    rest_ms = long_rest_q ? timing_shadow.rest_after_full_ms
                          : timing_shadow.rest_after_empty_ms;
    since_phase = req.now_ms - phase_start_q;
    if (!relay_on_q) begin
      // a zero phase start means the timer never ran: request the pump now
      if (phase_start_q == '0 || since_phase > rest_ms) begin
        phase_start_q = req.now_ms;
        pump_request_q = 1'b1;
      end
    end else if (since_phase > timing_shadow.on_time_ms) begin
      phase_start_q = req.now_ms;
      pump_request_q = 1'b0;
    end
    if (req.float_level != float_seen_q) begin
      float_seen_q = req.float_level;
      if (req.float_level) long_rest_q = 1'b1;
    end
    if (float_seen_q && relay_on_q) pump_request_q = 1'b0;
    since_change = req.now_ms - last_change_q;
    if (pump_request_q != relay_on_q && since_change > timing_shadow.relay_lockout_ms) begin
      led_stale_q = 1'b1;
      long_rest_q = float_seen_q;
      notice = float_seen_q;
      relay_on_q = pump_request_q;
      phase_start_q = req.now_ms;
      last_change_q = req.now_ms;
    end
    if (req.now_ms < phase_start_q) phase_start_q = req.now_ms;
    res.relay_drive = relay_on_q;
    res.led_one = led_pair_q[0];
    res.led_two = led_pair_q[1];
    res.current_mode = mode_q;
    res.full_notice = notice;
    return res;
  endfunction

  function automatic in_t make_req(input logic [TimeW-1:0] now, input logic flt,
                                   input logic press, input logic rvalid,
                                   input logic [1:0] rmode);
    in_t req;
    req.now_ms = now;
    req.float_level = flt;
    req.button_press = press;
    req.remote_mode_valid = rvalid;
    req.remote_mode = rmode;
    return req;
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the request.
  task automatic send_request(input in_t req);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= req;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_status_q.push_back(predict_pump_step(req));
    sent_count++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all four timing registers back to back; hold valid across the burst.
  task automatic write_timing(input cfg_t timing);
    logic [CfgIdxW-1:0] idx_list[4];
    logic [TimeW-1:0]   val_list[4];
    idx_list = '{CfgOnTime, CfgRestFull, CfgRestEmpty, CfgLockout};
    val_list = '{timing.on_time_ms, timing.rest_after_full_ms,
                 timing.rest_after_empty_ms, timing.relay_lockout_ms};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx_list[i];
      cfg_ch.wdata <= val_list[i];
      @(posedge clk_i);
      while (!cfg_ch.ready) @(posedge clk_i);
      reg_write_count++;
    end
    cfg_ch.valid <= 1'b0;
    timing_shadow = timing;
  endtask

  // Mostly a running clock with a plausible tank; now and then a random request.
  task automatic send_pump_traffic(input int count, input int max_step);
    in_t req;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        req = make_req($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      end else begin
        clock_ms = clock_ms + $urandom_range(0, max_step);
        if ($urandom_range(0, 11) == 0) tank_full = ~tank_full;
        req = make_req(clock_ms, tank_full, $urandom_range(0, 15) == 0,
                       $urandom_range(0, 11) == 0, 2'($urandom_range(0, 3)));
      end
      send_request(req);
    end
  endtask

  task automatic test_default_timing();
    send_request(make_req(32'd0, 1'b0, 1'b0, 1'b0, ModeAuto));
    send_request(make_req(32'd5000, 1'b0, 1'b0, 1'b0, ModeAuto));
    send_request(make_req(32'd20001, 1'b0, 1'b0, 1'b0, ModeAuto));
    // float rises while pumping, first inside the lockout then past it
    send_request(make_req(32'd40000, 1'b1, 1'b0, 1'b0, ModeAuto));
    send_request(make_req(32'd40002, 1'b1, 1'b0, 1'b0, ModeAuto));
    send_request(make_req(32'd50000, 1'b0, 1'b1, 1'b0, ModeAuto));
    send_request(make_req(32'd60003, 1'b0, 1'b0, 1'b0, ModeAuto));
    send_request(make_req(32'd60004, 1'b0, 1'b1, 1'b1, ModeOff));
    send_request(make_req(32'd80010, 1'b0, 1'b1, 1'b1, 2'd3));
    send_request(make_req(32'd80011, 1'b0, 1'b0, 1'b1, 2'd3));
    send_request(make_req(32'd100020, 1'b0, 1'b0, 1'b1, ModeOn));
    send_request(make_req(32'd130030, 1'b0, 1'b0, 1'b1, ModeOff));
    send_request(make_req(32'd150040, 1'b0, 1'b0, 1'b1, ModeAuto));
    send_request(make_req(32'd1400000, 1'b0, 1'b0, 1'b0, ModeAuto));
    send_request(make_req(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0, ModeAuto));
    send_request(make_req(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, ModeAuto));
    // timestamp wraps behind the phase start
    send_request(make_req(32'd0, 1'b1, 1'b0, 1'b0, ModeAuto));
    send_request(make_req(32'd5, 1'b0, 1'b1, 1'b0, ModeAuto));
    send_request(make_req(32'h8000_0000, 1'b0, 1'b1, 1'b0, ModeAuto));
    send_request(make_req(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, ModeOff));
    send_request(make_req(32'h5555_5555, 1'b1, 1'b1, 1'b1, ModeOn));
    send_request(make_req(32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, ModeAuto));
    wait_idle();
  endtask

  task automatic test_timing_extremes();
    write_timing('{on_time_ms: '0, rest_after_full_ms: '0,
                   rest_after_empty_ms: '0, relay_lockout_ms: '0});
    clock_ms = 32'd1;
    send_pump_traffic(25, 3);
    wait_idle();
    write_timing('{on_time_ms: '1, rest_after_full_ms: '1,
                   rest_after_empty_ms: '1, relay_lockout_ms: '1});
    send_pump_traffic(25, 50);
    wait_idle();
  endtask

  task automatic test_random_timing();
    cfg_t timing;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        timing = '{on_time_ms: $urandom, rest_after_full_ms: $urandom,
                   rest_after_empty_ms: $urandom, relay_lockout_ms: $urandom};
      end else begin
        timing = '{on_time_ms: $urandom_range(0, 150),
                   rest_after_full_ms: $urandom_range(0, 400),
                   rest_after_empty_ms: $urandom_range(0, 120),
                   relay_lockout_ms: $urandom_range(0, 40)};
      end
      write_timing(timing);
      // start some phases just short of the wrap
      clock_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FF00 : $urandom_range(1, 1000);
      send_pump_traffic(90, $urandom_range(1, 40));
      wait_idle();
    end
  endtask

  task automatic test_result_backpressure();
    write_timing('{on_time_ms: 32'd60, rest_after_full_ms: 32'd200,
                   rest_after_empty_ms: 32'd40, relay_lockout_ms: 32'd8});
    hold_requests++;
    send_pump_traffic(40, 20);
    hold_requests++;
    send_pump_traffic(40, 20);
    wait_idle();
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    write_timing('{on_time_ms: RestEmptyRst, rest_after_full_ms: 32'd300,
                   rest_after_empty_ms: 32'd90, relay_lockout_ms: 32'd5});
    @(posedge clk_i);
    write_timing('{on_time_ms: OnTimeRst / 1000, rest_after_full_ms: RestFullRst / 30000,
                   rest_after_empty_ms: 32'd50, relay_lockout_ms: LockoutRst / 1000});
    send_pump_traffic(90, 15);
  endtask

  // result side: random short stalls plus an occasional long hold
  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left <= LongHoldCycles;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_gap_left != 0) begin
      sink_gap_left <= sink_gap_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      sink_gap_left <= $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_status
    out_t want;
    out_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_status_q.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("%0t: unexpected status word %p", $realtime, got);
      end else begin
        want = expected_status_q.pop_front();
        checked_count++;
        if (got.full_notice === 1'b1) full_stop_count++;
        if (got.relay_drive !== want.relay_drive || got.led_one !== want.led_one ||
            got.led_two !== want.led_two || got.current_mode !== want.current_mode ||
            got.full_notice !== want.full_notice) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("%0t: status mismatch: expected %p, got %p", $realtime, want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_status_q.size());
      $display("float_switch_pump_timer_core_test failed");
      $finish;
    end
  end

  initial begin
    timing_shadow = '{on_time_ms: OnTimeRst, rest_after_full_ms: RestFullRst,
                      rest_after_empty_ms: RestEmptyRst, relay_lockout_ms: LockoutRst};
    mode_q = ModeAuto;
    led_stale_q = 1'b1;
    led_pair_q = 2'b00;
    float_seen_q = 1'b0;
    relay_on_q = 1'b0;
    pump_request_q = 1'b0;
    long_rest_q = 1'b0;
    phase_start_q = '0;
    last_change_q = '0;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.wdata <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_timing();
    test_timing_extremes();
    test_random_timing();
    test_result_backpressure();
    test_steady_stream();

    wait_idle();
    $display("sent %0d requests, checked %0d status words, %0d register writes",
             sent_count, checked_count, reg_write_count);
    $display("saw %0d full-tank stops across default, extreme and random timings",
             full_stop_count);
    if (error_count == 0 && expected_status_q.size() == 0) begin
      $display("float_switch_pump_timer_core_test passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("float_switch_pump_timer_core_test failed");
    end
    $finish;
  end

endmodule
